/* sv/ctpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpf_pkg
// Types, codes and constants shared by the timer pair forward unit.
// ----------------------------------------------------------------------------
package ctpf_pkg;

    localparam int UNITS_DEFAULT       = 2;
    localparam int ROUND_LIMIT_DEFAULT = 10000;

    localparam int CFG_W  = 25;
    localparam int CIDX_W = 3;
    localparam int WAIT_W = 25;

    localparam logic [3:0] OFS_PRA  = 4'd0;
    localparam logic [3:0] OFS_PRB  = 4'd1;
    localparam logic [3:0] OFS_TALO = 4'd4;
    localparam logic [3:0] OFS_TAHI = 4'd5;
    localparam logic [3:0] OFS_TBLO = 4'd6;
    localparam logic [3:0] OFS_TBHI = 4'd7;
    localparam logic [3:0] OFS_ICR  = 4'd13;
    localparam logic [3:0] OFS_CRA  = 4'd14;
    localparam logic [3:0] OFS_CRB  = 4'd15;

    localparam logic [7:0] RST_PRA = 8'h10;
    localparam logic [7:0] RST_PRB = 8'hFF;
    localparam logic [7:0] RST_ICR = 8'h81;
    localparam logic [7:0] RST_CRA = 8'h01;
    localparam logic [7:0] ONESHOT = 8'h08;

    localparam logic [24:0] FAIL_RESET = 25'h1FFFFFF;
    localparam logic [15:0] CPS_RESET  = 16'd19656;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_FORWARD = 2'd2,
        MODE_RESTORE = 2'd3
    } ctpf_mode_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_FAIL_MARKER = 3'd0,
        CFG_PSID        = 3'd1,
        CFG_TIMER_PSID  = 3'd2,
        CFG_CPS         = 3'd3,
        CFG_RSID        = 3'd4
    } ctpf_cfg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } ctpf_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        unit;
        logic [3:0]  reg_offset;
        logic [7:0]  write_data;
        logic [15:0] time_limit;
        logic        cpu_irq_flag;
    } ctpf_cmd_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [WAIT_W-1:0] wait_cycles;
        logic              interrupt_found;
    } ctpf_result_t;

    typedef struct packed {
        logic [15:0] cnt_a;
        logic [15:0] cnt_b;
        logic [15:0] lat_a;
        logic [15:0] lat_b;
        logic [7:0]  cra;
        logic [7:0]  crb;
        logic [7:0]  mask;
        logic [7:0]  status;
        logic        susp_a;
        logic        susp_b;
        logic [16:0] waited;
    } ctpf_work_t;

    typedef struct packed {
        logic done;
        logic found;
        logic fail;
    } ctpf_step_t;

endpackage

/* sv/ctpf_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpf_round
// One underflow round of a forward transaction: picks the next underflow,
// advances the wait, reloads, stops one-shots and flags armed interrupts.
// ----------------------------------------------------------------------------
module ctpf_round (
    input  ctpf_pkg::ctpf_work_t work,
    input  logic [15:0]          limit,
    output ctpf_pkg::ctpf_work_t work_next,
    output ctpf_pkg::ctpf_step_t step
);

    logic        linked;
    logic        st0;
    logic        st1;
    logic        run_a;
    logic        run_b;
    logic        equal;
    logic        a_first;
    logic        c2_run;
    logic [15:0] c1;
    logic [16:0] sum;
    logic [15:0] rem;
    logic [16:0] rem_full;

    always_comb
    begin
        work_next = work;
        step      = '0;
        linked    = (work.crb[6:5] == 2'b10);
        st0       = work.cra[0] & ~work.susp_a;
        st1       = work.crb[0] & (~work.susp_b | (linked & st0));
        run_a     = st0;
        run_b     = work.crb[0] & ~work.susp_b;
        equal     = run_a & run_b & (work.cnt_a == work.cnt_b);
        a_first   = run_a & (~run_b | (work.cnt_a < work.cnt_b));
        c2_run    = a_first ? run_b : run_a;
        rem_full  = {1'b0, limit} - work.waited;
        rem       = rem_full[15:0];
        c1        = (linked & st1) ? work.cnt_a : (a_first ? work.cnt_a : work.cnt_b);
        sum       = work.waited + {1'b0, c1};

        if (!(st0 | st1) || !(work.mask[0] | work.mask[1]))
        begin
            step.done = 1'b1;
            step.fail = 1'b1;
        end
        else if (linked && st1)
        begin
            if (!st0)
            begin
                step.done = 1'b1;
                step.fail = 1'b1;
            end
            else
            begin
                if (work.cnt_a == 16'd0)
                    work_next.susp_a = 1'b1;
                if (sum >= {1'b0, limit})
                begin
                    work_next.cnt_a = work.cnt_a - rem;
                    step.done = 1'b1;
                    step.fail = 1'b1;
                end
                else
                begin
                    work_next.waited = sum;
                    work_next.cnt_a  = work.lat_a;
                    if (work.lat_a != 16'd0)
                        work_next.susp_a = 1'b0;
                    work_next.status[0] = 1'b1;
                    if (work.cra[3])
                        work_next.cra[0] = 1'b0;
                    if (work.cnt_b == 16'd0)
                    begin
                        work_next.cnt_b = work.lat_b;
                        if (work.lat_b != 16'd0)
                            work_next.susp_b = 1'b0;
                        work_next.status[1] = 1'b1;
                        if (work.crb[3])
                            work_next.crb[0] = 1'b0;
                        if (work.mask[1])
                        begin
                            work_next.status[7] = 1'b1;
                            step.done  = 1'b1;
                            step.found = 1'b1;
                        end
                    end
                    else
                        work_next.cnt_b = work.cnt_b - 16'd1;
                end
            end
        end
        else
        begin
            if (run_a && work.cnt_a == 16'd0)
                work_next.susp_a = 1'b1;
            if (run_b && work.cnt_b == 16'd0)
                work_next.susp_b = 1'b1;
            if (sum >= {1'b0, limit})
            begin
                step.done = 1'b1;
                step.fail = 1'b1;
                if (equal || a_first || c2_run)
                    work_next.cnt_a = work.cnt_a - rem;
                if (equal || !a_first || c2_run)
                    work_next.cnt_b = work.cnt_b - rem;
            end
            else
            begin
                work_next.waited = sum;
                if (equal || a_first)
                begin
                    work_next.cnt_a = work.lat_a;
                    if (work.lat_a != 16'd0)
                        work_next.susp_a = 1'b0;
                    work_next.status[0] = 1'b1;
                    if (work.cra[3])
                        work_next.cra[0] = 1'b0;
                end
                else if (c2_run)
                    work_next.cnt_a = work.cnt_a - c1;
                if (equal || !a_first)
                begin
                    work_next.cnt_b = work.lat_b;
                    if (work.lat_b != 16'd0)
                        work_next.susp_b = 1'b0;
                    work_next.status[1] = 1'b1;
                    if (work.crb[3])
                        work_next.crb[0] = 1'b0;
                end
                else if (c2_run)
                    work_next.cnt_b = work.cnt_b - c1;
                if ((equal && (work.mask[0] | work.mask[1]))
                    || (!equal && a_first && work.mask[0])
                    || (!equal && !a_first && work.mask[1]))
                begin
                    work_next.status[7] = 1'b1;
                    step.done  = 1'b1;
                    step.found = 1'b1;
                end
            end
        end
    end

endmodule

/* sv/cia_timer_pair_forward_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_timer_pair_forward_unit
// Two interval timer units with register access and next-interrupt forward.
// ----------------------------------------------------------------------------
// channel   direction  signals                      transaction at
// command   in         start, busy, cmd             start & !busy
// result    out        done, result                 done (one cycle)
// config    in         cfg_we, cfg_index, cfg_data  cfg_we
//
// Write, read and restore transactions give their result in the cycle after start.
// Forward runs one underflow round per cycle in the round unit, with busy
// high until the result cycle.
// Reset clears all unit registers, latches, suspend and status flags.
// The receiver cannot stall; done pulses for one cycle per transaction.
// ----------------------------------------------------------------------------
module cia_timer_pair_forward_unit #(
    parameter int UNITS       = ctpf_pkg::UNITS_DEFAULT,
    parameter int ROUND_LIMIT = ctpf_pkg::ROUND_LIMIT_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ctpf_pkg::ctpf_cmd_t           cmd,
    output logic                          done,
    output ctpf_pkg::ctpf_result_t        result,
    input  logic                          cfg_we,
    input  logic [ctpf_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [ctpf_pkg::CFG_W-1:0]    cfg_data
);

    localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;

    ctpf_pkg::ctpf_state_t  state_reg, state_next;
    logic [7:0]             regs_reg  [UNITS][16];
    logic [15:0]            latch_reg [UNITS][2];
    logic                   susp_reg  [UNITS][2];
    logic [7:0]             stat_reg  [UNITS];
    ctpf_pkg::ctpf_work_t   work_reg;
    ctpf_pkg::ctpf_work_t   work_next;
    ctpf_pkg::ctpf_step_t   step;
    logic [15:0]            limit_reg;
    logic [15:0]            rcnt_reg;
    logic [UW-1:0]          unit_reg;
    logic                   done_reg;
    ctpf_pkg::ctpf_result_t result_reg;

    logic [24:0]            fail_marker_reg;
    logic                   psid_reg;
    logic                   tdpsid_reg;
    logic [15:0]            cps_reg;
    logic                   rsid_reg;

    logic [UW-1:0]          uidx;
    logic                   accept;
    logic                   fwd_start;
    logic                   blocked;
    logic                   cap_hit;
    logic                   finish;

    assign uidx      = (UNITS == 1) ? '0 : UW'(cmd.unit);
    assign accept    = start && !busy;
    assign blocked   = !psid_reg && cmd.cpu_irq_flag && (uidx == '0);
    assign fwd_start = accept && (cmd.mode == ctpf_pkg::MODE_FORWARD) && !blocked;
    assign cap_hit   = (rcnt_reg == 16'(ROUND_LIMIT - 1));
    assign finish    = (state_reg == ctpf_pkg::ST_RUN) && (step.done || cap_hit);
    assign busy      = (state_reg == ctpf_pkg::ST_RUN);
    assign done      = done_reg;
    assign result    = result_reg;

    ctpf_round u_round (
        .work      (work_reg),
        .limit     (limit_reg),
        .work_next (work_next),
        .step      (step)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctpf_pkg::ST_IDLE:
                if (fwd_start)
                    state_next = ctpf_pkg::ST_RUN;
            ctpf_pkg::ST_RUN:
                if (finish)
                    state_next = ctpf_pkg::ST_IDLE;
            default:
                state_next = ctpf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ctpf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_marker_reg <= ctpf_pkg::FAIL_RESET;
            psid_reg        <= 1'b0;
            tdpsid_reg      <= 1'b0;
            cps_reg         <= ctpf_pkg::CPS_RESET;
            rsid_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ctpf_pkg::CFG_FAIL_MARKER: fail_marker_reg <= cfg_data;
                ctpf_pkg::CFG_PSID:        psid_reg        <= cfg_data[0];
                ctpf_pkg::CFG_TIMER_PSID:  tdpsid_reg      <= cfg_data[0];
                ctpf_pkg::CFG_CPS:         cps_reg         <= cfg_data[15:0];
                ctpf_pkg::CFG_RSID:        rsid_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwd_start)
        begin
            work_reg.cnt_a  <= {regs_reg[uidx][ctpf_pkg::OFS_TAHI],
                                regs_reg[uidx][ctpf_pkg::OFS_TALO]};
            work_reg.cnt_b  <= {regs_reg[uidx][ctpf_pkg::OFS_TBHI],
                                regs_reg[uidx][ctpf_pkg::OFS_TBLO]};
            work_reg.lat_a  <= latch_reg[uidx][0];
            work_reg.lat_b  <= latch_reg[uidx][1];
            work_reg.cra    <= regs_reg[uidx][ctpf_pkg::OFS_CRA];
            work_reg.crb    <= regs_reg[uidx][ctpf_pkg::OFS_CRB];
            work_reg.mask   <= regs_reg[uidx][ctpf_pkg::OFS_ICR];
            work_reg.status <= stat_reg[uidx];
            work_reg.susp_a <= susp_reg[uidx][0];
            work_reg.susp_b <= susp_reg[uidx][1];
            work_reg.waited <= '0;
            limit_reg       <= cmd.time_limit;
            unit_reg        <= uidx;
            rcnt_reg        <= '0;
        end
        else if (state_reg == ctpf_pkg::ST_RUN)
        begin
            work_reg <= work_next;
            rcnt_reg <= rcnt_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < UNITS; u++)
            begin
                for (int o = 0; o < 16; o++)
                    regs_reg[u][o] <= '0;
                latch_reg[u][0] <= '0;
                latch_reg[u][1] <= '0;
                susp_reg[u][0]  <= 1'b0;
                susp_reg[u][1]  <= 1'b0;
                stat_reg[u]     <= '0;
            end
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= finish || (accept && !fwd_start);
            if (finish)
            begin
                regs_reg[unit_reg][ctpf_pkg::OFS_TALO] <= work_next.cnt_a[7:0];
                regs_reg[unit_reg][ctpf_pkg::OFS_TAHI] <= work_next.cnt_a[15:8];
                regs_reg[unit_reg][ctpf_pkg::OFS_TBLO] <= work_next.cnt_b[7:0];
                regs_reg[unit_reg][ctpf_pkg::OFS_TBHI] <= work_next.cnt_b[15:8];
                regs_reg[unit_reg][ctpf_pkg::OFS_CRA]  <= work_next.cra;
                regs_reg[unit_reg][ctpf_pkg::OFS_CRB]  <= work_next.crb;
                susp_reg[unit_reg][0] <= work_next.susp_a;
                susp_reg[unit_reg][1] <= work_next.susp_b;
                stat_reg[unit_reg]    <= work_next.status;
                result_reg.read_data  <= '0;
                if (step.done && step.fail)
                    result_reg.wait_cycles <= fail_marker_reg;
                else
                    result_reg.wait_cycles <= 25'(work_next.waited);
                result_reg.interrupt_found <= step.done && step.found;
            end
            else if (accept)
            begin
                result_reg.read_data <= (cmd.mode == ctpf_pkg::MODE_READ)
                    ? ((cmd.reg_offset == ctpf_pkg::OFS_ICR) ? stat_reg[uidx]
                                                              : regs_reg[uidx][cmd.reg_offset])
                    : 8'd0;
                result_reg.wait_cycles <= (cmd.mode == ctpf_pkg::MODE_FORWARD && blocked)
                    ? fail_marker_reg : 25'd0;
                result_reg.interrupt_found <= 1'b0;
                unique case (cmd.mode)
                    ctpf_pkg::MODE_WRITE:
                    begin
                        if (!(uidx == '0 && cmd.reg_offset <= ctpf_pkg::OFS_PRB))
                        begin
                            if (cmd.reg_offset == ctpf_pkg::OFS_ICR)
                            begin
                                if (cmd.write_data[7])
                                    regs_reg[uidx][ctpf_pkg::OFS_ICR] <=
                                        regs_reg[uidx][ctpf_pkg::OFS_ICR]
                                        | {3'b000, cmd.write_data[4:0]};
                                else
                                    regs_reg[uidx][ctpf_pkg::OFS_ICR] <=
                                        regs_reg[uidx][ctpf_pkg::OFS_ICR]
                                        & ~{3'b000, cmd.write_data[4:0]};
                            end
                            else
                            begin
                                regs_reg[uidx][cmd.reg_offset] <= cmd.write_data;
                                if (cmd.reg_offset[3:2] == 2'b01)
                                begin
                                    if (cmd.reg_offset[0])
                                    begin
                                        latch_reg[uidx][cmd.reg_offset[1]][15:8] <=
                                            cmd.write_data;
                                        if ({cmd.write_data,
                                             latch_reg[uidx][cmd.reg_offset[1]][7:0]} != 16'd0)
                                            susp_reg[uidx][cmd.reg_offset[1]] <= 1'b0;
                                    end
                                    else
                                    begin
                                        latch_reg[uidx][cmd.reg_offset[1]][7:0] <=
                                            cmd.write_data;
                                        if ({latch_reg[uidx][cmd.reg_offset[1]][15:8],
                                             cmd.write_data} != 16'd0)
                                            susp_reg[uidx][cmd.reg_offset[1]] <= 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    ctpf_pkg::MODE_READ:
                    begin
                        if (cmd.reg_offset == ctpf_pkg::OFS_ICR)
                            stat_reg[uidx] <= '0;
                    end
                    ctpf_pkg::MODE_FORWARD: ;
                    ctpf_pkg::MODE_RESTORE:
                    begin
                        regs_reg[0][ctpf_pkg::OFS_PRA] <= ctpf_pkg::RST_PRA;
                        regs_reg[0][ctpf_pkg::OFS_PRB] <= ctpf_pkg::RST_PRB;
                        regs_reg[0][ctpf_pkg::OFS_ICR] <= ctpf_pkg::RST_ICR;
                        regs_reg[0][ctpf_pkg::OFS_CRA] <= ctpf_pkg::RST_CRA;
                        regs_reg[0][ctpf_pkg::OFS_CRB] <= ctpf_pkg::ONESHOT;
                        if (!tdpsid_reg)
                        begin
                            regs_reg[0][ctpf_pkg::OFS_TALO] <= cps_reg[7:0];
                            regs_reg[0][ctpf_pkg::OFS_TAHI] <= cps_reg[15:8];
                        end
                        if (rsid_reg && UNITS > 1)
                        begin
                            regs_reg[UNITS-1 > 0 ? 1 : 0][ctpf_pkg::OFS_CRA] <=
                                ctpf_pkg::ONESHOT;
                            regs_reg[UNITS-1 > 0 ? 1 : 0][ctpf_pkg::OFS_CRB] <=
                                ctpf_pkg::ONESHOT;
                        end
                        for (int u = 0; u < UNITS; u++)
                        begin
                            if (u == 0 && !tdpsid_reg)
                                latch_reg[u][0] <= cps_reg;
                            else
                                latch_reg[u][0] <= {regs_reg[u][ctpf_pkg::OFS_TAHI],
                                                    regs_reg[u][ctpf_pkg::OFS_TALO]};
                            latch_reg[u][1] <= {regs_reg[u][ctpf_pkg::OFS_TBHI],
                                                regs_reg[u][ctpf_pkg::OFS_TBLO]};
                            susp_reg[u][0]  <= 1'b0;
                            susp_reg[u][1]  <= 1'b0;
                            stat_reg[u]     <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a forward is still running");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result strobe without a transaction");

    a_run_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && $past(cmd.mode) == ctpf_pkg::MODE_FORWARD)
        else $error("busy without a forward transaction");

endmodule

/* tb/cia_timer_pair_forward_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_timer_pair_forward_unit_tb
// Drives register writes, reads, restores and forward commands into the
// timer pair block and checks every result against a cycle-free model of
// both timer units: counters, latches, suspend flags, mask and status.
// ----------------------------------------------------------------------------
module cia_timer_pair_forward_unit_tb;

    localparam int unsigned STOPPED_MARK = 32'h1FFFFF8;
    localparam int          ROUNDS       = ctpf_pkg::ROUND_LIMIT_DEFAULT;

    class timer_pair_scoreboard;
        logic [7:0]  regs [2][16];
        logic [15:0] latch [2][2];
        bit          susp [2][2];
        logic [7:0]  status [2];
        logic [24:0] fail_marker;
        bit          psid, timer_psid, rsid;
        logic [15:0] cps;
        ctpf_pkg::ctpf_result_t expected_results[$];
        int          errors;

        function new();
            for (int u = 0; u < 2; u++)
            begin
                for (int o = 0; o < 16; o++) regs[u][o] = '0;
                for (int t = 0; t < 2; t++)
                begin
                    latch[u][t] = '0;
                    susp[u][t]  = 0;
                end
                status[u] = '0;
            end
            fail_marker = ctpf_pkg::FAIL_RESET;
            psid = 0;
            timer_psid = 0;
            rsid = 0;
            cps = ctpf_pkg::CPS_RESET;
            errors = 0;
        endfunction

        function void set_cfg(ctpf_pkg::ctpf_cfg_idx_t idx, logic [ctpf_pkg::CFG_W-1:0] v);
            case (idx)
                ctpf_pkg::CFG_FAIL_MARKER: fail_marker = v[24:0];
                ctpf_pkg::CFG_PSID:        psid = v[0];
                ctpf_pkg::CFG_TIMER_PSID:  timer_psid = v[0];
                ctpf_pkg::CFG_CPS:         cps = v[15:0];
                ctpf_pkg::CFG_RSID:        rsid = v[0];
                default: ;
            endcase
        endfunction

        function logic [15:0] counter(int u, int t);
            return {regs[u][ctpf_pkg::OFS_TAHI + 2 * t], regs[u][ctpf_pkg::OFS_TALO + 2 * t]};
        endfunction

        function void set_counter(int u, int t, logic [15:0] v);
            regs[u][ctpf_pkg::OFS_TALO + 2 * t] = v[7:0];
            regs[u][ctpf_pkg::OFS_TAHI + 2 * t] = v[15:8];
        endfunction

        function bit linked(int u);
            return (regs[u][ctpf_pkg::OFS_CRB] & 8'h60) == 8'h40;
        endfunction

        function bit started(int u, int t);
            if (!regs[u][ctpf_pkg::OFS_CRA + t][0]) return 0;
            if (!susp[u][t]) return 1;
            return t == 1 && linked(u) && started(u, 0);
        endfunction

        function bit armed(int u, int t);
            return regs[u][ctpf_pkg::OFS_ICR][t];
        endfunction

        function bit continuous(int u, int t);
            return !regs[u][ctpf_pkg::OFS_CRA + t][3];
        endfunction

        function int unsigned running_count(int u, int t);
            logic [15:0] c;
            if (!susp[u][t] && started(u, t))
            begin
                c = counter(u, t);
                if (c == 0) susp[u][t] = 1;
                return c;
            end
            return STOPPED_MARK;
        endfunction

        function void reload(int u, int t);
            set_counter(u, t, latch[u][t]);
            if (latch[u][t] > 0) susp[u][t] = 0;
            status[u][t] = 1'b1;
        endfunction

        function void reduce(int u, int t, int unsigned d);
            set_counter(u, t, counter(u, t) - d[15:0]);
        endfunction

        function void stop_one_shot(int u, int t);
            if (!continuous(u, t)) regs[u][ctpf_pkg::OFS_CRA + t][0] = 1'b0;
        endfunction

        function void bus_write(int u, logic [3:0] off, logic [7:0] v);
            int t;
            if (u == 0 && off <= ctpf_pkg::OFS_PRB) return;
            if (off == ctpf_pkg::OFS_ICR)
            begin
                if (v[7]) regs[u][ctpf_pkg::OFS_ICR] = regs[u][ctpf_pkg::OFS_ICR] | (v & 8'h1F);
                else regs[u][ctpf_pkg::OFS_ICR] = regs[u][ctpf_pkg::OFS_ICR] & ~(v & 8'h1F);
                return;
            end
            if (off >= ctpf_pkg::OFS_TALO && off <= ctpf_pkg::OFS_TBHI)
            begin
                t = (off - ctpf_pkg::OFS_TALO) >> 1;
                if (off[0]) latch[u][t][15:8] = v;
                else latch[u][t][7:0] = v;
                if (latch[u][t] > 0) susp[u][t] = 0;
            end
            regs[u][off] = v;
        endfunction

        function void init_write(int u, logic [3:0] off, logic [7:0] v);
            bus_write(u, off, v);
            regs[u][off] = v;
        endfunction

        function int unsigned forward(int u, int unsigned lim, output bit found);
            int unsigned waited, ca, cb, c1, c2;
            int t1, t2;
            waited = 0;
            found = 0;
            for (int r = 0; r < ROUNDS; r++)
            begin
                if (!(started(u, 0) || started(u, 1))) return fail_marker;
                if (!(armed(u, 0) || armed(u, 1))) return fail_marker;
                if (linked(u) && started(u, 1))
                begin
                    if (!started(u, 0)) return fail_marker;
                    ca = running_count(u, 0);
                    if (waited + ca >= lim)
                    begin
                        reduce(u, 0, lim - waited);
                        return fail_marker;
                    end
                    waited += ca;
                    reload(u, 0);
                    stop_one_shot(u, 0);
                    if (counter(u, 1) == 0)
                    begin
                        reload(u, 1);
                        stop_one_shot(u, 1);
                        if (armed(u, 1))
                        begin
                            status[u][7] = 1'b1;
                            found = 1;
                            return waited;
                        end
                    end
                    else reduce(u, 1, 1);
                end
                else
                begin
                    ca = running_count(u, 0);
                    cb = running_count(u, 1);
                    if (ca == cb)
                    begin
                        if (waited + cb >= lim)
                        begin
                            reduce(u, 1, lim - waited);
                            reduce(u, 0, lim - waited);
                            return fail_marker;
                        end
                        waited += cb;
                        reload(u, 1);
                        reload(u, 0);
                        stop_one_shot(u, 1);
                        stop_one_shot(u, 0);
                        if (armed(u, 1) || armed(u, 0))
                        begin
                            status[u][7] = 1'b1;
                            found = 1;
                            return waited;
                        end
                    end
                    else
                    begin
                        t1 = (ca < cb) ? 0 : 1;
                        t2 = 1 - t1;
                        c1 = (ca < cb) ? ca : cb;
                        c2 = (ca < cb) ? cb : ca;
                        if (waited + c1 >= lim)
                        begin
                            reduce(u, t1, lim - waited);
                            if (c2 != STOPPED_MARK) reduce(u, t2, lim - waited);
                            return fail_marker;
                        end
                        waited += c1;
                        reload(u, t1);
                        if (c2 != STOPPED_MARK) reduce(u, t2, c1);
                        stop_one_shot(u, t1);
                        if (armed(u, t1))
                        begin
                            status[u][7] = 1'b1;
                            found = 1;
                            return waited;
                        end
                    end
                end
            end
            return waited;
        endfunction

        function void restore();
            init_write(0, ctpf_pkg::OFS_PRA, ctpf_pkg::RST_PRA);
            init_write(0, ctpf_pkg::OFS_PRB, ctpf_pkg::RST_PRB);
            init_write(0, ctpf_pkg::OFS_ICR, ctpf_pkg::RST_ICR);
            init_write(0, ctpf_pkg::OFS_CRA, ctpf_pkg::RST_CRA);
            init_write(0, ctpf_pkg::OFS_CRB, ctpf_pkg::ONESHOT);
            if (!timer_psid)
            begin
                init_write(0, ctpf_pkg::OFS_TALO, cps[7:0]);
                init_write(0, ctpf_pkg::OFS_TAHI, cps[15:8]);
            end
            if (rsid)
            begin
                init_write(1, ctpf_pkg::OFS_CRA, ctpf_pkg::ONESHOT);
                init_write(1, ctpf_pkg::OFS_CRB, ctpf_pkg::ONESHOT);
            end
            for (int u = 0; u < 2; u++)
            begin
                for (int t = 0; t < 2; t++)
                begin
                    latch[u][t] = counter(u, t);
                    susp[u][t]  = 0;
                end
                status[u] = '0;
            end
        endfunction

        function void note_command(ctpf_pkg::ctpf_cmd_t c);
            ctpf_pkg::ctpf_result_t r;
            bit found;
            int u;
            r = '0;
            u = c.unit;
            case (ctpf_pkg::ctpf_mode_t'(c.mode))
                ctpf_pkg::MODE_WRITE: bus_write(u, c.reg_offset, c.write_data);
                ctpf_pkg::MODE_READ:
                begin
                    if (c.reg_offset == ctpf_pkg::OFS_ICR)
                    begin
                        r.read_data = status[u];
                        status[u] = '0;
                    end
                    else r.read_data = regs[u][c.reg_offset];
                end
                ctpf_pkg::MODE_FORWARD:
                begin
                    if (!psid && c.cpu_irq_flag && u == 0) r.wait_cycles = fail_marker;
                    else
                    begin
                        r.wait_cycles = 25'(forward(u, c.time_limit, found));
                        r.interrupt_found = found;
                    end
                end
                default: restore();
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(ctpf_pkg::ctpf_result_t got);
            ctpf_pkg::ctpf_result_t exp_r;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.read_data !== exp_r.read_data || got.wait_cycles !== exp_r.wait_cycles
                || got.interrupt_found !== exp_r.interrupt_found)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp rd=%h wait=%h irq=%b got rd=%h wait=%h irq=%b",
                             exp_r.read_data, exp_r.wait_cycles, exp_r.interrupt_found,
                             got.read_data, got.wait_cycles, got.interrupt_found);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ctpf_pkg::ctpf_cmd_t cmd;
    logic done;
    ctpf_pkg::ctpf_result_t result;
    logic cfg_we;
    logic [ctpf_pkg::CIDX_W-1:0] cfg_index;
    logic [ctpf_pkg::CFG_W-1:0] cfg_data;

    timer_pair_scoreboard sb;
    int burst_left;
    int items_sent;

    cia_timer_pair_forward_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(result);
    end

    task automatic issue(ctpf_pkg::ctpf_cmd_t c);
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
        sb.note_command(c);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic op(ctpf_pkg::ctpf_mode_t m, int u, logic [3:0] off, logic [7:0] d,
                      logic [15:0] lim, bit irq);
        ctpf_pkg::ctpf_cmd_t c;
        c.mode = m;
        c.unit = u[0];
        c.reg_offset = off;
        c.write_data = d;
        c.time_limit = lim;
        c.cpu_irq_flag = irq;
        issue(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [24:0] fm, bit ps, bit tp, logic [15:0] cp, bit rs);
        logic [ctpf_pkg::CFG_W-1:0] vals [5];
        vals[0] = fm;
        vals[1] = ctpf_pkg::CFG_W'(ps);
        vals[2] = ctpf_pkg::CFG_W'(tp);
        vals[3] = ctpf_pkg::CFG_W'(cp);
        vals[4] = ctpf_pkg::CFG_W'(rs);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= ctpf_pkg::CIDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.set_cfg(ctpf_pkg::ctpf_cfg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_latch();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'($urandom);
            2: return 16'($urandom_range(0, 1000));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'd0;
            default: return 16'($urandom_range(1, 3000));
        endcase
    endfunction

    // timer setup, mask, one to three forwards, then a read-back, mostly of status
    task automatic scenario();
        int u;
        logic [15:0] la, lb;
        u = $urandom_range(0, 1);
        la = pick_latch();
        lb = pick_latch();
        op(ctpf_pkg::MODE_WRITE, u, ctpf_pkg::OFS_TALO, la[7:0], $urandom, $urandom);
        op(ctpf_pkg::MODE_WRITE, u, ctpf_pkg::OFS_TAHI, la[15:8], $urandom, $urandom);
        op(ctpf_pkg::MODE_WRITE, u, ctpf_pkg::OFS_TBLO, lb[7:0], $urandom, $urandom);
        op(ctpf_pkg::MODE_WRITE, u, ctpf_pkg::OFS_TBHI, lb[15:8], $urandom, $urandom);
        op(ctpf_pkg::MODE_WRITE, u, ctpf_pkg::OFS_CRA,
           ($urandom & 8'hF6) | ($urandom_range(0, 4) != 0), $urandom, $urandom);
        op(ctpf_pkg::MODE_WRITE, u, ctpf_pkg::OFS_CRB,
           ($urandom & 8'h96) | ($urandom_range(0, 3) != 0)
           | (($urandom_range(0, 2) == 0) ? 8'h40 : {1'b0, $urandom_range(0, 3), 5'b0}),
           $urandom, $urandom);
        op(ctpf_pkg::MODE_WRITE, u, ctpf_pkg::OFS_ICR, 8'h80 | $urandom_range(0, 31),
           $urandom, $urandom);
        if ($urandom_range(0, 3) == 0)
            op(ctpf_pkg::MODE_WRITE, u, ctpf_pkg::OFS_ICR, $urandom_range(0, 127),
               $urandom, $urandom);
        repeat ($urandom_range(1, 3))
            op(ctpf_pkg::MODE_FORWARD, u, $urandom, $urandom, pick_limit(),
               $urandom_range(0, 5) == 0);
        op(ctpf_pkg::MODE_READ, u,
           ($urandom_range(0, 3) != 0) ? ctpf_pkg::OFS_ICR : 4'($urandom), $urandom,
           $urandom, $urandom);
    endtask

    task automatic random_phase(int n);
        ctpf_pkg::ctpf_cmd_t c;
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 3) != 0) scenario();
            else
            begin
                c = ctpf_pkg::ctpf_cmd_t'($urandom);
                if (c.mode == ctpf_pkg::MODE_FORWARD && $urandom_range(0, 7) != 0)
                    c.time_limit = pick_limit();
                issue(c);
            end
            if ($urandom_range(0, 60) == 0) drain();
        end
    endtask

    initial
    begin
        #60000000;
        $display("cia_timer_pair_forward_unit test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 4;
        items_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        op(ctpf_pkg::MODE_RESTORE, 0, 4'd0, 8'd0, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_READ, 0, ctpf_pkg::OFS_ICR, 8'd0, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_FORWARD, 0, 4'd0, 8'd0, 16'hFFFF, 1'b1);
        op(ctpf_pkg::MODE_FORWARD, 0, 4'd0, 8'd0, 16'hFFFF, 1'b0);
        op(ctpf_pkg::MODE_READ, 0, ctpf_pkg::OFS_ICR, 8'd0, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 0, ctpf_pkg::OFS_PRA, 8'hFF, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_READ, 0, ctpf_pkg::OFS_PRA, 8'd0, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, 4'd2, 8'hFF, 16'hFFFF, 1'b1);
        op(ctpf_pkg::MODE_READ, 1, 4'd2, 8'd0, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_TALO, 8'd0, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_TAHI, 8'd0, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_CRA, 8'h01, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_ICR, 8'h81, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_FORWARD, 1, 4'd0, 8'd0, 16'd100, 1'b0);
        op(ctpf_pkg::MODE_FORWARD, 1, 4'd0, 8'd0, 16'd100, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_TALO, 8'd3, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_TBLO, 8'd2, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_CRB, 8'h41, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_ICR, 8'h01, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_ICR, 8'h82, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_FORWARD, 1, 4'd0, 8'd0, 16'hFFFF, 1'b0);
        // round cap: unarmed fast A, armed slow B
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_TALO, 8'd1, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_CRB, 8'h01, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_WRITE, 1, ctpf_pkg::OFS_TBHI, 8'hFF, 16'd0, 1'b0);
        op(ctpf_pkg::MODE_FORWARD, 1, 4'd0, 8'd0, 16'hFFFF, 1'b0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_config(25'h0, 1'b1, 1'b1, 16'h0, 1'b1);
                1: set_config(25'h1FFFFFF, 1'b0, 1'b0, 16'hFFFF, 1'b0);
                2: set_config(25'($urandom), 1'b1, 1'b0, 16'($urandom_range(1, 500)), 1'b1);
                default: set_config(25'($urandom), $urandom, $urandom, 16'($urandom),
                                    $urandom);
            endcase
            op(ctpf_pkg::MODE_RESTORE, $urandom, $urandom, $urandom, $urandom, $urandom);
            random_phase(120);
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("cia_timer_pair_forward_unit test passed");
        else
            $display("cia_timer_pair_forward_unit test failed");
        $finish;
    end
endmodule
